### src/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

    // Fixed field widths of the two channels and of the configuration port.
    localparam int COORD_W     = 32;
    localparam int STEPS_CFG_W = 5;
    localparam int TENSION_W   = 15;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_IDX_W   = 1;

    // Sample position t is unsigned Q0.16 and reaches 1.0, hence 17 bits.
    localparam int T_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_STEPS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TENSION       = 1'd1;

    localparam logic [STEPS_CFG_W-1:0] STEPS_RESET   = 5'd8;
    localparam logic [TENSION_W-1:0]   TENSION_RESET = 15'd8192;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      series_last;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      point_valid;
        logic                      run_last;
        logic                      series_end;
    } out_item_t;

endpackage

### src/cardinal_spline_tessellator_core.sv
`timescale 1ns / 1ps

// Cardinal spline tessellator. Control points arrive on the s_ channel, one transfer each;
// sampled curve points leave on the m_ channel through a single output register.
// The third point of a series yields the first point and the first segment, every later
// point one inner segment, and a point flagged series_last also the closing segment.
// A series that ends before its third point yields one marker with point_valid low.
// The block takes one point at a time; s_ready is high only while it waits for a point.
// Per point: restoring division for the sample spacing, a setup state per segment,
// then the states ST_TADV to ST_EMIT for each sample (steps samples per segment).
// All of the sample multiplications run through one 33 x 33 signed multiplier.
// On a third point the stored first point goes out from ST_FIRST through the output
// register ahead of the first curve sample.
// A stalled receiver stops the sequencer at the next result until the register drains;
// the next sample is worked out while a finished one waits. Points that give no result
// pass from idle through ST_DONE and back. Reset (aresetn low, synchronous) empties the
// output register, starts a new series and sets segment_steps to 8 and tension to 0.5.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and belong in
// idle periods only.
module cardinal_spline_tessellator_core
    import cst_pkg::*;
#(
    parameter int MAX_STEPS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam int STEP_W   = $clog2(MAX_STEPS + 1);
    localparam int OUT_BITS = (COORD_WIDTH < COORD_W) ? COORD_WIDTH : COORD_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MUL_W    = DIFF_W;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int H_W      = T_W + 1;
    localparam int HC_W     = T_W + 3;
    localparam int Q_W      = PROD_W - 30;
    localparam int VAL_W    = Q_W + 1;
    localparam int DCNT_W   = $clog2(T_W);

    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(T_W - 1);
    localparam logic [STEP_W-1:0] MAX_S    = STEP_W'(MAX_STEPS);
    localparam logic signed [VAL_W-1:0] SAT_MAX =
        VAL_W'((longint'(1) <<< (OUT_BITS - 1)) - longint'(1));
    localparam logic signed [VAL_W-1:0] SAT_MIN = ~SAT_MAX;

    typedef enum logic [18:0] {
        ST_IDLE  = 19'h00001,
        ST_FIRST = 19'h00002,
        ST_MARK  = 19'h00004,
        ST_DIV   = 19'h00008,
        ST_SETUP = 19'h00010,
        ST_TADV  = 19'h00020,
        ST_TT    = 19'h00040,
        ST_T3    = 19'h00080,
        ST_HC    = 19'h00100,
        ST_K0    = 19'h00200,
        ST_K1    = 19'h00400,
        ST_K2    = 19'h00800,
        ST_P0    = 19'h01000,
        ST_P1    = 19'h02000,
        ST_P2    = 19'h04000,
        ST_P3    = 19'h08000,
        ST_FIN   = 19'h10000,
        ST_EMIT  = 19'h20000,
        ST_DONE  = 19'h40000
    } state_t;

    // Control registers.
    state_t                   state_reg, state_next;
    logic [STEPS_CFG_W-1:0]   steps_cfg_reg, steps_cfg_next;
    logic [TENSION_W-1:0]     tension_reg, tension_next;
    logic [1:0]               seen_reg, seen_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DCNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic [STEP_W-1:0]        n_reg, n_next;
    logic                     seg_end_reg, seg_end_next;
    logic                     coord_reg, coord_next;

    // Datapath registers.
    logic signed [COORD_W-1:0] win_reg [2][3];
    logic signed [COORD_W-1:0] win_next [2][3];
    in_item_t                  in_reg, in_next;
    logic [STEP_W-1:0]         steps_reg, steps_next;
    logic [STEP_W-1:0]         div_rem_reg, div_rem_next;
    logic [T_W-1:0]            q0_reg, q0_next;
    logic [STEP_W-1:0]         r0_reg, r0_next;
    logic [T_W-1:0]            t_reg, t_next;
    logic [STEP_W-1:0]         tr_reg, tr_next;
    logic [T_W-1:0]            t2_reg, t2_next;
    logic signed [H_W-1:0]     h01_reg, h01_next;
    logic signed [H_W-1:0]     h10_reg, h10_next;
    logic signed [H_W-1:0]     h11_reg, h11_next;
    logic signed [MUL_W-1:0]   k0_reg, k0_next;
    logic signed [MUL_W-1:0]   k1_reg, k1_next;
    logic signed [COORD_W-1:0] sa_reg [2];
    logic signed [COORD_W-1:0] sa_next [2];
    logic signed [DIFF_W-1:0]  sdab_reg [2];
    logic signed [DIFF_W-1:0]  sdab_next [2];
    logic signed [DIFF_W-1:0]  sd0_reg [2];
    logic signed [DIFF_W-1:0]  sd0_next [2];
    logic signed [DIFF_W-1:0]  sd1_reg [2];
    logic signed [DIFF_W-1:0]  sd1_next [2];
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  acc_reg, acc_next;
    logic signed [COORD_W-1:0] res_reg [2];
    logic signed [COORD_W-1:0] res_next [2];
    out_item_t                 out_reg, out_next;

    // Shared multiplier operands.
    logic signed [MUL_W-1:0]   mul_a, mul_b;

    logic                      slot_free;
    logic signed [COORD_W-1:0] in_pt [2];

    assign slot_free = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign in_pt[0]  = in_reg.point_x;
    assign in_pt[1]  = in_reg.point_y;

    assign prod_next = mul_a * mul_b;

    always_comb begin
        logic [STEP_W:0]          div_shift;
        logic [STEP_W:0]          tr_sum;
        logic [T_W+16:0]          rnd_t;
        logic [T_W-1:0]           t3;
        logic signed [HC_W-1:0]   t_s, t2_s, t3_s;
        logic signed [PROD_W-1:0] rnd_sum;
        logic signed [Q_W-1:0]    rnd_q;
        logic signed [VAL_W-1:0]  val;
        logic signed [DIFF_W-1:0] w0, w1, w2, p;
        logic                     final_seg;

        state_next     = state_reg;
        steps_cfg_next = steps_cfg_reg;
        tension_next   = tension_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !m_ready;
        div_cnt_next   = div_cnt_reg;
        n_next         = n_reg;
        seg_end_next   = seg_end_reg;
        coord_next     = coord_reg;
        win_next       = win_reg;
        in_next        = in_reg;
        steps_next     = steps_reg;
        div_rem_next   = div_rem_reg;
        q0_next        = q0_reg;
        r0_next        = r0_reg;
        t_next         = t_reg;
        tr_next        = tr_reg;
        t2_next        = t2_reg;
        h01_next       = h01_reg;
        h10_next       = h10_reg;
        h11_next       = h11_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        sa_next        = sa_reg;
        sdab_next      = sdab_reg;
        sd0_next       = sd0_reg;
        sd1_next       = sd1_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        mul_a          = '0;
        mul_b          = '0;

        div_shift = {div_rem_reg, (div_cnt_reg == '0)};
        tr_sum    = {1'b0, tr_reg} + {1'b0, r0_reg};
        // Rounded Q0.16 square or cube from the last product.
        rnd_t     = prod_reg[T_W+16:0] + (T_W+17)'(32768);
        t3        = rnd_t[T_W+15:16];
        t_s       = HC_W'(t_reg);
        t2_s      = HC_W'(t2_reg);
        t3_s      = HC_W'(t3);
        rnd_sum   = acc_reg + PROD_W'(64'sd536870912);
        rnd_q     = rnd_sum[PROD_W-1:30];
        val       = VAL_W'(sa_reg[coord_reg]) + VAL_W'(rnd_q);
        final_seg = seg_end_reg || !in_reg.series_last;
        w0        = '0;
        w1        = '0;
        w2        = '0;
        p         = '0;

        if (cfg_we) begin
            case (cfg_index)
                CFG_SEGMENT_STEPS: steps_cfg_next = cfg_wdata[STEPS_CFG_W-1:0];
                CFG_TENSION:       tension_next   = cfg_wdata[TENSION_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next      = s_data;
                    div_cnt_next = '0;
                    div_rem_next = '0;
                    q0_next      = '0;
                    seg_end_next = 1'b0;
                    if (steps_cfg_reg == '0) begin
                        steps_next = STEP_W'(1);
                    end else if (int'(steps_cfg_reg) > MAX_STEPS) begin
                        steps_next = MAX_S;
                    end else begin
                        steps_next = STEP_W'(steps_cfg_reg);
                    end
                    if (seen_reg == 2'd2) begin
                        state_next = ST_FIRST;
                    end else if (seen_reg == 2'd3) begin
                        state_next = ST_DIV;
                    end else if (s_data.series_last) begin
                        state_next = ST_MARK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FIRST: begin
                // The first control point of the series goes out ahead of its segment.
                if (slot_free) begin
                    out_next.out_x       = win_reg[0][1];
                    out_next.out_y       = win_reg[1][1];
                    out_next.point_valid = 1'b1;
                    out_next.run_last    = 1'b0;
                    out_next.series_end  = 1'b0;
                    out_valid_next       = 1'b1;
                    state_next           = ST_DIV;
                end
            end
            ST_MARK: begin
                if (slot_free) begin
                    out_next.out_x       = '0;
                    out_next.out_y       = '0;
                    out_next.point_valid = 1'b0;
                    out_next.run_last    = 1'b1;
                    out_next.series_end  = 1'b1;
                    out_valid_next       = 1'b1;
                    state_next           = ST_DONE;
                end
            end
            ST_DIV: begin
                // Restoring division of 1.0 (Q0.16) by the step count, one bit a cycle.
                if (div_shift >= {1'b0, steps_reg}) begin
                    div_rem_next = STEP_W'(div_shift - {1'b0, steps_reg});
                    q0_next      = {q0_reg[T_W-2:0], 1'b1};
                end else begin
                    div_rem_next = div_shift[STEP_W-1:0];
                    q0_next      = {q0_reg[T_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_cnt_reg == DIV_LAST) begin
                    r0_next    = (div_shift >= {1'b0, steps_reg}) ?
                                 STEP_W'(div_shift - {1'b0, steps_reg}) :
                                 div_shift[STEP_W-1:0];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                for (int c = 0; c < 2; c++) begin
                    w0 = DIFF_W'(win_reg[c][0]);
                    w1 = DIFF_W'(win_reg[c][1]);
                    w2 = DIFF_W'(win_reg[c][2]);
                    p  = DIFF_W'(in_pt[c]);
                    if (!seg_end_reg) begin
                        sa_next[c]   = win_reg[c][1];
                        sdab_next[c] = w2 - w1;
                        // The opening segment has no point before its start.
                        sd0_next[c]  = (seen_reg == 2'd3) ? (w2 - w0) : (w2 - w1);
                        sd1_next[c]  = p - w1;
                    end else begin
                        sa_next[c]   = win_reg[c][2];
                        sdab_next[c] = p - w2;
                        sd0_next[c]  = p - w1;
                        sd1_next[c]  = p - w2;
                    end
                end
                t_next     = '0;
                tr_next    = steps_reg >> 1;
                n_next     = '0;
                state_next = ST_TADV;
            end
            ST_TADV: begin
                // t moves on by 1/steps with the remainder carried exactly.
                n_next = n_reg + STEP_W'(1);
                if (tr_sum >= {1'b0, steps_reg}) begin
                    tr_next = STEP_W'(tr_sum - {1'b0, steps_reg});
                    t_next  = t_reg + q0_reg + T_W'(1);
                end else begin
                    tr_next = tr_sum[STEP_W-1:0];
                    t_next  = t_reg + q0_reg;
                end
                state_next = ST_TT;
            end
            ST_TT: begin
                mul_a      = MUL_W'(t_reg);
                mul_b      = MUL_W'(t_reg);
                state_next = ST_T3;
            end
            ST_T3: begin
                t2_next    = t3;
                mul_a      = MUL_W'(t3);
                mul_b      = MUL_W'(t_reg);
                state_next = ST_HC;
            end
            ST_HC: begin
                h01_next   = H_W'(3 * t2_s - 2 * t3_s);
                h10_next   = H_W'(t3_s - 2 * t2_s + t_s);
                h11_next   = H_W'(t3_s - t2_s);
                state_next = ST_K0;
            end
            ST_K0: begin
                mul_a      = MUL_W'(h10_reg);
                mul_b      = MUL_W'(tension_reg);
                state_next = ST_K1;
            end
            ST_K1: begin
                k0_next    = prod_reg[MUL_W-1:0];
                mul_a      = MUL_W'(h11_reg);
                mul_b      = MUL_W'(tension_reg);
                state_next = ST_K2;
            end
            ST_K2: begin
                k1_next    = prod_reg[MUL_W-1:0];
                coord_next = 1'b0;
                state_next = ST_P0;
            end
            ST_P0: begin
                mul_a      = MUL_W'(h01_reg);
                mul_b      = sdab_reg[coord_reg];
                state_next = ST_P1;
            end
            ST_P1: begin
                acc_next   = prod_reg <<< 14;
                mul_a      = k0_reg;
                mul_b      = sd0_reg[coord_reg];
                state_next = ST_P2;
            end
            ST_P2: begin
                acc_next   = acc_reg + prod_reg;
                mul_a      = k1_reg;
                mul_b      = sd1_reg[coord_reg];
                state_next = ST_P3;
            end
            ST_P3: begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (val > SAT_MAX) begin
                    res_next[coord_reg] = SAT_MAX[COORD_W-1:0];
                end else if (val < SAT_MIN) begin
                    res_next[coord_reg] = SAT_MIN[COORD_W-1:0];
                end else begin
                    res_next[coord_reg] = val[COORD_W-1:0];
                end
                if (!coord_reg) begin
                    coord_next = 1'b1;
                    state_next = ST_P0;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_next.out_x       = res_reg[0];
                    out_next.out_y       = res_reg[1];
                    out_next.point_valid = 1'b1;
                    out_next.run_last    = (n_reg == steps_reg) && final_seg;
                    out_next.series_end  = (n_reg == steps_reg) && final_seg &&
                                           in_reg.series_last;
                    out_valid_next       = 1'b1;
                    if (n_reg != steps_reg) begin
                        state_next = ST_TADV;
                    end else if (final_seg) begin
                        state_next = ST_DONE;
                    end else begin
                        seg_end_next = 1'b1;
                        state_next   = ST_SETUP;
                    end
                end
            end
            ST_DONE: begin
                for (int c = 0; c < 2; c++) begin
                    win_next[c][0] = win_reg[c][1];
                    win_next[c][1] = win_reg[c][2];
                    win_next[c][2] = in_pt[c];
                end
                if (in_reg.series_last) begin
                    seen_next = 2'd0;
                end else if (seen_reg != 2'd3) begin
                    seen_next = seen_reg + 2'd1;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            steps_cfg_reg <= STEPS_RESET;
            tension_reg   <= TENSION_RESET;
            seen_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            n_reg         <= '0;
            seg_end_reg   <= 1'b0;
            coord_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            steps_cfg_reg <= steps_cfg_next;
            tension_reg   <= tension_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
            n_reg         <= n_next;
            seg_end_reg   <= seg_end_next;
            coord_reg     <= coord_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg     <= win_next;
        in_reg      <= in_next;
        steps_reg   <= steps_next;
        div_rem_reg <= div_rem_next;
        q0_reg      <= q0_next;
        r0_reg      <= r0_next;
        t_reg       <= t_next;
        tr_reg      <= tr_next;
        t2_reg      <= t2_next;
        h01_reg     <= h01_next;
        h10_reg     <= h10_next;
        h11_reg     <= h11_next;
        k0_reg      <= k0_next;
        k1_reg      <= k1_next;
        sa_reg      <= sa_next;
        sdab_reg    <= sdab_next;
        sd0_reg     <= sd0_next;
        sd1_reg     <= sd1_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

endmodule

### test/tb_cardinal_spline_tessellator_core.sv
`timescale 1ns / 1ps

module tb_cardinal_spline_tessellator_core;
    import cst_pkg::*;

    localparam int MAX_STEPS       = 16;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int POINTS_PER_PASS = 34;
    localparam int PASSES          = 8;
    localparam longint COORD_MAX   = 64'sd2147483647;
    localparam longint COORD_MIN   = -64'sd2147483648;

    localparam int STEP_PLAN[PASSES]    = '{1, 16, 0, 31, 17, 3, 5, 12};
    localparam int TENSION_PLAN[PASSES] = '{0, 32767, 16384, 1, 8192, 24576, 4096, 20000};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    cardinal_spline_tessellator_core #(
        .MAX_STEPS   (MAX_STEPS),
        .COORD_WIDTH (COORD_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: the three most recent control points and the register copies.
    longint                 window_x[3];
    longint                 window_y[3];
    int                     series_count    = 0;
    logic [STEPS_CFG_W-1:0] steps_setting   = STEPS_RESET;
    logic [TENSION_W-1:0]   tension_setting = TENSION_RESET;

    in_item_t  point_queue[$];
    out_item_t expected_samples[$];
    out_item_t oldest_sample;

    int unsigned points_queued    = 0;
    int unsigned points_taken     = 0;
    int unsigned samples_checked  = 0;
    int unsigned mismatch_count   = 0;
    int unsigned settings_written = 0;
    int unsigned cycle_count      = 0;
    bit          steady_flow      = 1'b0;

    function automatic longint active_steps();
        longint s;
        s = longint'(steps_setting);
        if (s < 1) s = 1;
        if (s > MAX_STEPS) s = MAX_STEPS;
        return s;
    endfunction

    function automatic logic [31:0] hermite_coord(longint a, longint b, longint d0, longint d1,
                                                  longint h01, longint h10, longint h11);
        longint tq;
        longint acc;
        longint v;
        tq  = longint'(tension_setting);
        acc = h01 * (b - a) * 64'sd16384 + h10 * (tq * d0) + h11 * (tq * d1);
        v   = a + ((acc + (64'sd1 <<< 29)) >>> 30);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[31:0];
    endfunction

    task automatic queue_sample(logic [31:0] x, logic [31:0] y, logic valid);
        out_item_t r;
        r             = '0;
        r.out_x       = x;
        r.out_y       = y;
        r.point_valid = valid;
        expected_samples.push_back(r);
    endtask

    // One curve segment from a to b, sampled at t = n/steps for n = 1 .. steps.
    task automatic queue_segment(longint ax, longint ay, longint bx, longint by,
                                 longint d0x, longint d0y, longint d1x, longint d1y);
        longint s;
        longint n;
        longint t;
        longint t2;
        longint t3;
        longint h01;
        longint h10;
        longint h11;
        s = active_steps();
        for (n = 1; n <= s; n++) begin
            t   = (n * 65536 + s / 2) / s;
            t2  = (t * t + 32768) >>> 16;
            t3  = (t2 * t + 32768) >>> 16;
            h01 = 3 * t2 - 2 * t3;
            h10 = t3 - 2 * t2 + t;
            h11 = t3 - t2;
            queue_sample(hermite_coord(ax, bx, d0x, d1x, h01, h10, h11),
                         hermite_coord(ay, by, d0y, d1y, h01, h10, h11), 1'b1);
        end
    endtask

    task automatic predict_point(in_item_t p);
        longint    x;
        longint    y;
        int        first;
        out_item_t r;
        x     = $signed(p.point_x);
        y     = $signed(p.point_y);
        first = expected_samples.size();
        if (series_count == 2) begin
            queue_sample(window_x[1][31:0], window_y[1][31:0], 1'b1);
            queue_segment(window_x[1], window_y[1], window_x[2], window_y[2],
                          window_x[2] - window_x[1], window_y[2] - window_y[1],
                          x - window_x[1], y - window_y[1]);
        end else if (series_count >= 3) begin
            queue_segment(window_x[1], window_y[1], window_x[2], window_y[2],
                          window_x[2] - window_x[0], window_y[2] - window_y[0],
                          x - window_x[1], y - window_y[1]);
        end else if (p.series_last) begin
            queue_sample('0, '0, 1'b0);
        end
        // The closing segment only exists once a series has at least three points.
        if (series_count >= 2 && p.series_last) begin
            queue_segment(window_x[2], window_y[2], x, y,
                          x - window_x[1], y - window_y[1],
                          x - window_x[2], y - window_y[2]);
        end
        window_x[0] = window_x[1];
        window_x[1] = window_x[2];
        window_x[2] = x;
        window_y[0] = window_y[1];
        window_y[1] = window_y[2];
        window_y[2] = y;
        if (series_count < 3) series_count++;
        if (p.series_last) series_count = 0;
        if (expected_samples.size() > first) begin
            r            = expected_samples[expected_samples.size() - 1];
            r.run_last   = 1'b1;
            r.series_end = p.series_last;
            expected_samples[expected_samples.size() - 1] = r;
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            mismatch_count++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Input side: a new point is offered only once the previous transfer has happened.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_point(s_data);
                points_taken++;
            end
            if (!s_valid || s_ready) begin
                if (point_queue.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 8)) begin
                    s_data  <= point_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                samples_checked++;
                if (expected_samples.size() == 0) begin
                    mismatch_count++;
                    $error("result with nothing expected: x %0d, y %0d, valid %0b",
                           $signed(m_data.out_x), $signed(m_data.out_y),
                           m_data.point_valid);
                end else begin
                    oldest_sample = expected_samples.pop_front();
                    check_field("out_x", $signed(oldest_sample.out_x), $signed(m_data.out_x));
                    check_field("out_y", $signed(oldest_sample.out_y), $signed(m_data.out_y));
                    check_field("point_valid", oldest_sample.point_valid, m_data.point_valid);
                    check_field("run_last", oldest_sample.run_last, m_data.run_last);
                    check_field("series_end", oldest_sample.series_end, m_data.series_end);
                end
            end
            m_ready <= steady_flow || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_samples.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_point(logic [31:0] x, logic [31:0] y, logic last);
        in_item_t p;
        p.point_x     = x;
        p.point_y     = y;
        p.series_last = last;
        point_queue.push_back(p);
        points_queued++;
    endtask

    // Coordinate styles: full range, a random walk, corner values, and values near zero.
    function automatic logic [31:0] pick_coord(logic [31:0] prev, int style);
        case (style)
            0: begin
                return $urandom();
            end
            1: begin
                return prev + $urandom_range(0, 262143) - 32'd131072;
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return $urandom();
                endcase
            end
            default: begin
                return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            end
        endcase
    endfunction

    task automatic queue_series(int len, int style);
        logic [31:0] px;
        logic [31:0] py;
        int          k;
        px = $urandom();
        py = $urandom();
        for (k = 0; k < len; k++) begin
            px = pick_coord(px, style);
            py = pick_coord(py, style);
            add_point(px, py, k == len - 1);
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SEGMENT_STEPS)
            steps_setting = val[STEPS_CFG_W-1:0];
        else if (idx == CFG_TENSION)
            tension_setting = val[TENSION_W-1:0];
        settings_written++;
    endtask

    // Waits until every queued point has been taken and every predicted result has arrived,
    // then gives the block time to finish any point that produced no result.
    task automatic wait_idle();
        while (points_taken != points_queued || expected_samples.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int pass;
        int target;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset settings.
        add_point(32'h0000_0000, 32'h0000_0000, 1'b1);
        add_point(32'h0001_0000, 32'h0001_0000, 1'b0);
        add_point(32'h0002_0000, 32'hFFFF_0000, 1'b1);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        add_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        add_point(32'h0000_0000, 32'h8000_0000, 1'b1);
        add_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        add_point(32'h0001_0000, 32'h0000_0000, 1'b0);
        add_point(32'h0002_0000, 32'h0001_0000, 1'b0);
        add_point(32'h0003_0000, 32'hFFFF_0000, 1'b0);
        add_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        add_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        wait_idle();

        for (pass = 0; pass < PASSES; pass++) begin
            if (pass == PASSES - 1) begin
                write_register(CFG_SEGMENT_STEPS,
                               CFG_DATA_W'($urandom_range(1, MAX_STEPS)));
                write_register(CFG_TENSION, CFG_DATA_W'($urandom_range(0, 32767)));
            end else begin
                write_register(CFG_SEGMENT_STEPS, CFG_DATA_W'(STEP_PLAN[pass]));
                write_register(CFG_TENSION, CFG_DATA_W'(TENSION_PLAN[pass]));
            end
            steady_flow = (pass == 4);
            target = points_queued + POINTS_PER_PASS;
            while (points_queued < target) begin
                // Mostly complete series; now and then one that ends too early.
                if ($urandom_range(0, 9) == 0)
                    queue_series($urandom_range(1, 2), $urandom_range(0, 3));
                else
                    queue_series($urandom_range(3, 9), $urandom_range(0, 3));
            end
            wait_idle();
        end
        steady_flow = 1'b0;

        $display("Sent %0d control points over %0d register writes; %0d results compared.",
                 points_taken, settings_written, samples_checked);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### cardinal_spline_tessellator_core.f
src/cst_pkg.sv
src/cardinal_spline_tessellator_core.sv
test/tb_cardinal_spline_tessellator_core.sv
